// ===== hdl/qvr_pkg.sv =====
`default_nettype none

package qvr_pkg;

   localparam int QVR_VEC_WIDTH  = 16;
   localparam int QVR_QUAT_WIDTH = 16;

endpackage

`default_nettype wire

// ===== hdl/qvr_req_if.sv =====
`default_nettype none

interface qvr_req_if #(
   parameter int QUAT_WIDTH = qvr_pkg::QVR_QUAT_WIDTH,
   parameter int VEC_WIDTH  = qvr_pkg::QVR_VEC_WIDTH
);
   logic                         valid;
   logic                         ready;
   logic signed [QUAT_WIDTH-1:0] quat_w;
   logic signed [QUAT_WIDTH-1:0] quat_x;
   logic signed [QUAT_WIDTH-1:0] quat_y;
   logic signed [QUAT_WIDTH-1:0] quat_z;
   logic signed [VEC_WIDTH-1:0]  vec_x;
   logic signed [VEC_WIDTH-1:0]  vec_y;
   logic signed [VEC_WIDTH-1:0]  vec_z;

   modport source (
      output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
      input  ready
   );

   modport sink (
      input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/qvr_rsp_if.sv =====
`default_nettype none

interface qvr_rsp_if #(
   parameter int VEC_WIDTH = qvr_pkg::QVR_VEC_WIDTH
);
   logic                        valid;
   logic                        ready;
   logic signed [VEC_WIDTH-1:0] rot_x;
   logic signed [VEC_WIDTH-1:0] rot_y;
   logic signed [VEC_WIDTH-1:0] rot_z;
   logic                        saturated;

   modport source (
      output valid, rot_x, rot_y, rot_z, saturated,
      input  ready
   );

   modport sink (
      input  valid, rot_x, rot_y, rot_z, saturated,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/quaternion_vector_rotate_top.sv =====
// Rotates a signed vector by a Q2.(QUAT_WIDTH-2) quaternion as q * (v, 0) * conj(q), exact
// until the final round-half-up shift by 2*(QUAT_WIDTH-2) bits, with each component
// saturated to VEC_WIDTH bits and a flag raised on any clipping. The quaternion is used as
// given (no normalization), so the result scales by |q|^2. Five register stages: first
// products, first sums, second products, second sums, round/saturate into the output
// register. One transaction is taken every cycle while rsp.ready stays high. Each stage
// holds its own valid bit and loads whenever it is empty or the stage after it moves, so
// bubbles close up under backpressure and a stall neither drops nor repeats a transaction.
`default_nettype none

module quaternion_vector_rotate_top #(
   parameter int VEC_WIDTH  = qvr_pkg::QVR_VEC_WIDTH,
   parameter int QUAT_WIDTH = qvr_pkg::QVR_QUAT_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   qvr_req_if.sink    req,
   qvr_rsp_if.source  rsp
);
   import qvr_pkg::*;

   localparam int NS   = 5;
   localparam int PW   = QUAT_WIDTH + VEC_WIDTH;
   localparam int TW   = PW + 2;
   localparam int MW   = TW + QUAT_WIDTH;
   localparam int RW   = MW + 2;
   localparam int FRAC = 2 * (QUAT_WIDTH - 2);

   localparam logic signed [RW:0] HALF =
      {{(RW + 1 - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
   localparam logic signed [RW:0] VMAX =
      {{(RW + 2 - VEC_WIDTH){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
   localparam logic signed [RW:0] VMIN = ~VMAX;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] stage_ready;

   // stage 1: q * v partial products
   logic signed [QUAT_WIDTH-1:0] q1w_ff, q1x_ff, q1y_ff, q1z_ff;
   logic signed [PW-1:0] xvx_ff, yvy_ff, zvz_ff, wvx_ff, yvz_ff, zvy_ff;
   logic signed [PW-1:0] wvy_ff, xvz_ff, zvx_ff, wvz_ff, xvy_ff, yvx_ff;
   logic signed [PW-1:0] xvx_in, yvy_in, zvz_in, wvx_in, yvz_in, zvy_in;
   logic signed [PW-1:0] wvy_in, xvz_in, zvx_in, wvz_in, xvy_in, yvx_in;

   // stage 2: t = q * (v, 0)
   logic signed [QUAT_WIDTH-1:0] q2w_ff, q2x_ff, q2y_ff, q2z_ff;
   logic signed [TW-1:0] tw_ff, tx_ff, ty_ff, tz_ff;
   logic signed [TW-1:0] tw_in, tx_in, ty_in, tz_in;

   // stage 3: t * conj(q) partial products
   logic signed [MW-1:0] txw_ff, twx_ff, tyz_ff, tzy_ff;
   logic signed [MW-1:0] txz_ff, tyw_ff, twy_ff, tzx_ff;
   logic signed [MW-1:0] twz_ff, txy_ff, tyx_ff, tzw_ff;
   logic signed [MW-1:0] txw_in, twx_in, tyz_in, tzy_in;
   logic signed [MW-1:0] txz_in, tyw_in, twy_in, tzx_in;
   logic signed [MW-1:0] twz_in, txy_in, tyx_in, tzw_in;

   // stage 4: vector part of the rotated quaternion
   logic signed [RW-1:0] rx_ff, ry_ff, rz_ff;
   logic signed [RW-1:0] rx_in, ry_in, rz_in;

   // stage 5: output register
   logic signed [VEC_WIDTH-1:0] rot_x_ff, rot_y_ff, rot_z_ff;
   logic signed [VEC_WIDTH-1:0] rot_x_in, rot_y_in, rot_z_in;
   logic                        sat_ff, sat_in;
   logic [VEC_WIDTH:0]          clip_x, clip_y, clip_z;

   function automatic logic [VEC_WIDTH:0] round_clip(input logic signed [RW-1:0] v);
      logic signed [RW:0] rnd;
      logic signed [RW:0] sh;
      logic [VEC_WIDTH:0] res;
      rnd = (RW + 1)'(v) + HALF;
      sh  = rnd >>> FRAC;
      priority if (sh > VMAX) begin
         res = {1'b1, VMAX[VEC_WIDTH-1:0]};
      end else if (sh < VMIN) begin
         res = {1'b1, VMIN[VEC_WIDTH-1:0]};
      end else begin
         res = {1'b0, sh[VEC_WIDTH-1:0]};
      end
      return res;
   endfunction

   // a stage loads when it is empty or the next one moves
   always_comb begin
      stage_ready[NS-1] = ~valid_ff[NS-1] | rsp.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_ready[i] = ~valid_ff[i] | stage_ready[i+1];
      end
   end

   assign req.ready = stage_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= req.valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (stage_ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign xvx_in = PW'(req.quat_x) * PW'(req.vec_x);
   assign yvy_in = PW'(req.quat_y) * PW'(req.vec_y);
   assign zvz_in = PW'(req.quat_z) * PW'(req.vec_z);
   assign wvx_in = PW'(req.quat_w) * PW'(req.vec_x);
   assign yvz_in = PW'(req.quat_y) * PW'(req.vec_z);
   assign zvy_in = PW'(req.quat_z) * PW'(req.vec_y);
   assign wvy_in = PW'(req.quat_w) * PW'(req.vec_y);
   assign xvz_in = PW'(req.quat_x) * PW'(req.vec_z);
   assign zvx_in = PW'(req.quat_z) * PW'(req.vec_x);
   assign wvz_in = PW'(req.quat_w) * PW'(req.vec_z);
   assign xvy_in = PW'(req.quat_x) * PW'(req.vec_y);
   assign yvx_in = PW'(req.quat_y) * PW'(req.vec_x);

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         q1w_ff <= req.quat_w;
         q1x_ff <= req.quat_x;
         q1y_ff <= req.quat_y;
         q1z_ff <= req.quat_z;
         xvx_ff <= xvx_in;
         yvy_ff <= yvy_in;
         zvz_ff <= zvz_in;
         wvx_ff <= wvx_in;
         yvz_ff <= yvz_in;
         zvy_ff <= zvy_in;
         wvy_ff <= wvy_in;
         xvz_ff <= xvz_in;
         zvx_ff <= zvx_in;
         wvz_ff <= wvz_in;
         xvy_ff <= xvy_in;
         yvx_ff <= yvx_in;
      end
   end

   assign tw_in = -(TW'(xvx_ff) + TW'(yvy_ff) + TW'(zvz_ff));
   assign tx_in = TW'(wvx_ff) + TW'(yvz_ff) - TW'(zvy_ff);
   assign ty_in = TW'(wvy_ff) - TW'(xvz_ff) + TW'(zvx_ff);
   assign tz_in = TW'(wvz_ff) + TW'(xvy_ff) - TW'(yvx_ff);

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         q2w_ff <= q1w_ff;
         q2x_ff <= q1x_ff;
         q2y_ff <= q1y_ff;
         q2z_ff <= q1z_ff;
         tw_ff  <= tw_in;
         tx_ff  <= tx_in;
         ty_ff  <= ty_in;
         tz_ff  <= tz_in;
      end
   end

   assign txw_in = MW'(tx_ff) * MW'(q2w_ff);
   assign twx_in = MW'(tw_ff) * MW'(q2x_ff);
   assign tyz_in = MW'(ty_ff) * MW'(q2z_ff);
   assign tzy_in = MW'(tz_ff) * MW'(q2y_ff);
   assign txz_in = MW'(tx_ff) * MW'(q2z_ff);
   assign tyw_in = MW'(ty_ff) * MW'(q2w_ff);
   assign twy_in = MW'(tw_ff) * MW'(q2y_ff);
   assign tzx_in = MW'(tz_ff) * MW'(q2x_ff);
   assign twz_in = MW'(tw_ff) * MW'(q2z_ff);
   assign txy_in = MW'(tx_ff) * MW'(q2y_ff);
   assign tyx_in = MW'(ty_ff) * MW'(q2x_ff);
   assign tzw_in = MW'(tz_ff) * MW'(q2w_ff);

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         txw_ff <= txw_in;
         twx_ff <= twx_in;
         tyz_ff <= tyz_in;
         tzy_ff <= tzy_in;
         txz_ff <= txz_in;
         tyw_ff <= tyw_in;
         twy_ff <= twy_in;
         tzx_ff <= tzx_in;
         twz_ff <= twz_in;
         txy_ff <= txy_in;
         tyx_ff <= tyx_in;
         tzw_ff <= tzw_in;
      end
   end

   assign rx_in = RW'(txw_ff) - RW'(twx_ff) - RW'(tyz_ff) + RW'(tzy_ff);
   assign ry_in = RW'(txz_ff) + RW'(tyw_ff) - RW'(twy_ff) - RW'(tzx_ff);
   assign rz_in = RW'(tyx_ff) + RW'(tzw_ff) - RW'(twz_ff) - RW'(txy_ff);

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         rz_ff <= rz_in;
      end
   end

   assign clip_x   = round_clip(rx_ff);
   assign clip_y   = round_clip(ry_ff);
   assign clip_z   = round_clip(rz_ff);
   assign rot_x_in = clip_x[VEC_WIDTH-1:0];
   assign rot_y_in = clip_y[VEC_WIDTH-1:0];
   assign rot_z_in = clip_z[VEC_WIDTH-1:0];
   assign sat_in   = clip_x[VEC_WIDTH] | clip_y[VEC_WIDTH] | clip_z[VEC_WIDTH];

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         rot_x_ff <= rot_x_in;
         rot_y_ff <= rot_y_in;
         rot_z_ff <= rot_z_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp.valid     = valid_ff[NS-1];
   assign rsp.rot_x     = rot_x_ff;
   assign rsp.rot_y     = rot_y_ff;
   assign rsp.rot_z     = rot_z_ff;
   assign rsp.saturated = sat_ff;

   a_accept_fills_stage1 : assert property (
      @(posedge clock) disable iff (reset)
      req.valid && req.ready |=> valid_ff[0]
   ) else $error("accepted transaction did not reach the first stage");

   a_empty_output_takes : assert property (
      @(posedge clock) disable iff (reset)
      !valid_ff[NS-1] |-> req.ready
   ) else $error("input stalled while the output register is empty");

   a_stall_holds_sums : assert property (
      @(posedge clock) disable iff (reset)
      valid_ff[3] && !stage_ready[3] |=> valid_ff[3] && $stable(rx_ff) && $stable(ry_ff)
                                          && $stable(rz_ff)
   ) else $error("stalled sum stage lost its contents");

   a_saturated_at_limit : assert property (
      @(posedge clock) disable iff (reset)
      rsp.valid && rsp.saturated |->
         rsp.rot_x == VMAX[VEC_WIDTH-1:0] || rsp.rot_x == VMIN[VEC_WIDTH-1:0] ||
         rsp.rot_y == VMAX[VEC_WIDTH-1:0] || rsp.rot_y == VMIN[VEC_WIDTH-1:0] ||
         rsp.rot_z == VMAX[VEC_WIDTH-1:0] || rsp.rot_z == VMIN[VEC_WIDTH-1:0]
   ) else $error("saturation flag set with no component at a limit");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import qvr_pkg::*;

   localparam int QW          = QVR_QUAT_WIDTH;
   localparam int VW          = QVR_VEC_WIDTH;
   localparam int FRAC_BITS   = 2 * (QW - 2);
   localparam int PHASE_ITEMS = 578;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_PRINTED = 50;

   typedef logic signed [95:0] wide_type;

   localparam wide_type ROUND_HALF = wide_type'(1) <<< (FRAC_BITS - 1);
   localparam wide_type ROT_MAX    = (wide_type'(1) <<< (VW - 1)) - 1;
   localparam wide_type ROT_MIN    = -ROT_MAX - 1;

   typedef struct packed {
      logic signed [QW-1:0] quat_w;
      logic signed [QW-1:0] quat_x;
      logic signed [QW-1:0] quat_y;
      logic signed [QW-1:0] quat_z;
      logic signed [VW-1:0] vec_x;
      logic signed [VW-1:0] vec_y;
      logic signed [VW-1:0] vec_z;
   } rotation_request_type;

   typedef struct packed {
      logic signed [VW-1:0] rot_x;
      logic signed [VW-1:0] rot_y;
      logic signed [VW-1:0] rot_z;
      logic                 saturated;
   } rotation_type;

   class rotation_tracker_type;
      rotation_type expected_rotations[$];
      int           mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      function logic signed [VW-1:0] clip_component(input wide_type v, inout bit clipped);
         if (v > ROT_MAX) begin
            clipped = 1'b1;
            return ROT_MAX[VW-1:0];
         end
         if (v < ROT_MIN) begin
            clipped = 1'b1;
            return ROT_MIN[VW-1:0];
         end
         return v[VW-1:0];
      endfunction

      // q * (v, 0) * conj(q), exact until the final rounding shift
      function rotation_type rotate_vector(input rotation_request_type r);
         wide_type     qw, qx, qy, qz, vx, vy, vz;
         wide_type     tw, tx, ty, tz, rx, ry, rz;
         rotation_type res;
         bit           clipped;
         clipped = 1'b0;
         qw = wide_type'(r.quat_w);
         qx = wide_type'(r.quat_x);
         qy = wide_type'(r.quat_y);
         qz = wide_type'(r.quat_z);
         vx = wide_type'(r.vec_x);
         vy = wide_type'(r.vec_y);
         vz = wide_type'(r.vec_z);
         tw = -(qx * vx + qy * vy + qz * vz);
         tx = qw * vx + qy * vz - qz * vy;
         ty = qw * vy - qx * vz + qz * vx;
         tz = qw * vz + qx * vy - qy * vx;
         rx = tx * qw - tw * qx - ty * qz + tz * qy;
         ry = tx * qz + ty * qw - tw * qy - tz * qx;
         rz = -(tw * qz) - tx * qy + ty * qx + tz * qw;
         rx = (rx + ROUND_HALF) >>> FRAC_BITS;
         ry = (ry + ROUND_HALF) >>> FRAC_BITS;
         rz = (rz + ROUND_HALF) >>> FRAC_BITS;
         res.rot_x = clip_component(rx, clipped);
         res.rot_y = clip_component(ry, clipped);
         res.rot_z = clip_component(rz, clipped);
         res.saturated = clipped;
         return res;
      endfunction

      function void note_request(input rotation_request_type r);
         expected_rotations.push_back(rotate_vector(r));
      endfunction

      task report_mismatch(input string msg);
         mismatch_count++;
         if (mismatch_count <= MAX_PRINTED)
            $display("%0t mismatch: %s", $realtime, msg);
      endtask

      task check_rotation(input rotation_type got);
         rotation_type want;
         if (expected_rotations.size() == 0) begin
            report_mismatch("rotation arrived with no transaction pending");
            return;
         end
         want = expected_rotations.pop_front();
         if (got.rot_x !== want.rot_x)
            report_mismatch($sformatf("rot_x got %0d want %0d", got.rot_x, want.rot_x));
         if (got.rot_y !== want.rot_y)
            report_mismatch($sformatf("rot_y got %0d want %0d", got.rot_y, want.rot_y));
         if (got.rot_z !== want.rot_z)
            report_mismatch($sformatf("rot_z got %0d want %0d", got.rot_z, want.rot_z));
         if (got.saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %0b want %0b",
                                      got.saturated, want.saturated));
      endtask
   endclass

   logic clock;
   logic reset;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   cycle_count = 0;

   rotation_tracker_type tracker;

   qvr_req_if req_if ();
   qvr_rsp_if rsp_if ();

   quaternion_vector_rotate_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin : monitor
      rotation_request_type seen_req;
      rotation_type         seen_rot;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen_req.quat_w = req_if.quat_w;
            seen_req.quat_x = req_if.quat_x;
            seen_req.quat_y = req_if.quat_y;
            seen_req.quat_z = req_if.quat_z;
            seen_req.vec_x  = req_if.vec_x;
            seen_req.vec_y  = req_if.vec_y;
            seen_req.vec_z  = req_if.vec_z;
            tracker.note_request(seen_req);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen_rot.rot_x     = rsp_if.rot_x;
            seen_rot.rot_y     = rsp_if.rot_y;
            seen_rot.rot_z     = rsp_if.rot_z;
            seen_rot.saturated = rsp_if.saturated;
            tracker.check_rotation(seen_rot);
         end
      end
   end

   function automatic rotation_request_type make_request(input int w, input int x,
                                                         input int y, input int z,
                                                         input int vx, input int vy,
                                                         input int vz);
      rotation_request_type r;
      r.quat_w = QW'(w);
      r.quat_x = QW'(x);
      r.quat_y = QW'(y);
      r.quat_z = QW'(z);
      r.vec_x  = VW'(vx);
      r.vec_y  = VW'(vy);
      r.vec_z  = VW'(vz);
      return r;
   endfunction

   function automatic rotation_request_type random_request();
      rotation_request_type r;
      int                   kind;
      real                  ax, ay, az, norm, ang, s;
      kind = $urandom_range(9);
      r.quat_w = QW'($urandom);
      r.quat_x = QW'($urandom);
      r.quat_y = QW'($urandom);
      r.quat_z = QW'($urandom);
      r.vec_x  = VW'($urandom);
      r.vec_y  = VW'($urandom);
      r.vec_z  = VW'($urandom);
      if (kind < 6) begin
         // near-unit quaternion from a random axis and angle
         ax = real'(int'($urandom_range(2000)) - 1000);
         ay = real'(int'($urandom_range(2000)) - 1000);
         az = real'(int'($urandom_range(2000)) - 1000);
         norm = $sqrt(ax * ax + ay * ay + az * az);
         if (norm < 1.0) begin
            ax = 1.0;
            norm = 1.0;
         end
         ang = $urandom_range(62831) / 10000.0;
         s = $sin(ang / 2.0) * 16384.0 / norm;
         r.quat_w = QW'(int'($cos(ang / 2.0) * 16384.0) + int'($urandom_range(8)) - 4);
         r.quat_x = QW'(int'(ax * s) + int'($urandom_range(8)) - 4);
         r.quat_y = QW'(int'(ay * s) + int'($urandom_range(8)) - 4);
         r.quat_z = QW'(int'(az * s) + int'($urandom_range(8)) - 4);
         if ($urandom_range(1) == 1) begin
            r.vec_x = VW'(int'($urandom_range(32767)) - 16384);
            r.vec_y = VW'(int'($urandom_range(32767)) - 16384);
            r.vec_z = VW'(int'($urandom_range(32767)) - 16384);
         end
      end else if (kind == 8) begin
         r.vec_x = VW'(int'($urandom_range(510)) - 255);
         r.vec_y = VW'(int'($urandom_range(510)) - 255);
         r.vec_z = VW'(int'($urandom_range(510)) - 255);
      end else if (kind == 9) begin
         r.quat_w = QW'(int'($urandom_range(255)) - 128);
         r.quat_x = QW'(int'($urandom_range(255)) - 128);
         r.quat_y = QW'(int'($urandom_range(255)) - 128);
         r.quat_z = QW'(int'($urandom_range(255)) - 128);
      end
      if ($urandom_range(39) == 0) begin
         r.vec_x = '0;
         r.vec_y = '0;
         r.vec_z = '0;
      end
      return r;
   endfunction

   task automatic send_rotation(input rotation_request_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.quat_w <= item.quat_w;
      req_if.quat_x <= item.quat_x;
      req_if.quat_y <= item.quat_y;
      req_if.quat_z <= item.quat_z;
      req_if.vec_x  <= item.vec_x;
      req_if.vec_y  <= item.vec_y;
      req_if.vec_z  <= item.vec_z;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (tracker.expected_rotations.size() != 0) @(negedge clock);
   endtask

   initial begin
      tracker = new();
      reset = 1'b1;
      req_idle_pct = 28;
      rsp_idle_pct = 68;
      req_if.valid  = 1'b0;
      req_if.quat_w = '0;
      req_if.quat_x = '0;
      req_if.quat_y = '0;
      req_if.quat_z = '0;
      req_if.vec_x  = '0;
      req_if.vec_y  = '0;
      req_if.vec_z  = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 68 : 0;
         rsp_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 28 : 0;
         if (phase == 0) begin
            send_rotation(make_request(16384, 0, 0, 0, 32767, -32768, 1));
            send_rotation(make_request(16384, 0, 0, 0, 0, 0, 0));
            send_rotation(make_request(-32768, -32768, -32768, -32768, 0, 0, 0));
            send_rotation(make_request(32767, 32767, 32767, 32767, 0, 0, 0));
            send_rotation(make_request(0, 0, 0, 0, 32767, 32767, 32767));
            send_rotation(make_request(11585, 0, 0, 11585, 1000, 0, 0));
            send_rotation(make_request(11585, 11585, 0, 0, 0, 1000, 0));
            send_rotation(make_request(11585, 0, 11585, 0, 0, 0, 1000));
            send_rotation(make_request(0, 16384, 0, 0, 100, 200, 300));
            send_rotation(make_request(-32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768));
            send_rotation(make_request(32767, 32767, 32767, 32767, 32767, 32767, 32767));
            send_rotation(make_request(32767, 0, 0, 0, 10000, -10000, 1));
            send_rotation(make_request(-32768, 0, 0, 0, 8191, -8192, 3));
            send_rotation(make_request(8192, 0, 0, 0, 1, -1, 3));
            send_rotation(make_request(8192, 8192, 0, 0, 1, -1, 3));
            send_rotation(make_request(8192, 8192, 0, 0, -1, 1, -3));
            send_rotation(make_request(1, -1, 1, -1, 32767, -32768, 32767));
            send_rotation(make_request(32767, -32768, 32767, -32768, -32768, 32767, -32768));
         end
         repeat (PHASE_ITEMS) send_rotation(random_request());
         hold_until_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (tracker.mismatch_count == 0 && tracker.expected_rotations.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
